FILE: src/ssr_pkg.sv
package ssr_pkg;

   // Sizes of the block
   localparam int PATTERN_MAX     = 8;
   localparam int REPLACEMENT_MAX = 16;
   localparam int OUTPUT_CAPACITY = 8191;

   // The replacement registers hold sixteen bytes at most
   localparam int REPL_REG_BYTES = 16;
   localparam int REPL_EFF_MAX   = (REPLACEMENT_MAX < REPL_REG_BYTES) ?
                                   REPLACEMENT_MAX : REPL_REG_BYTES;

   // Widths
   localparam int BYTE_W   = 8;
   localparam int PLEN_W   = 4;
   localparam int RLEN_W   = 5;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int FILL_W   = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W    = (REPL_EFF_MAX > 1) ? $clog2(REPL_EFF_MAX) : 1;
   localparam int CNT_W    = $clog2(OUTPUT_CAPACITY + 1);

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LENGTH     = 3'd0,
      CSR_REPLACEMENT_LENGTH = 3'd1,
      CSR_PATTERN_BYTES      = 3'd2,
      CSR_REPLACEMENT_LOW    = 3'd3,
      CSR_REPLACEMENT_HIGH   = 3'd4
   } csr_index_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PASS,
      ST_REPL,
      ST_SHIFT,
      ST_FLUSH,
      ST_MARK
   } state_type;

   // Control of one window cell
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   // Control of the whole window row
   typedef struct packed {
      logic                   shift;
      logic [PATTERN_MAX-1:0] load;
   } win_ctrl_type;

endpackage

FILE: src/ssr_cell.sv
module ssr_cell
   import ssr_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [BYTE_W-1:0] load_byte,
   input  logic [BYTE_W-1:0] neighbor_byte,
   input  logic [BYTE_W-1:0] pattern_byte,
   input  logic              active,
   output logic [BYTE_W-1:0] data,
   output logic              eq
);

   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   // Take the neighbor's byte on a shift, the new byte on a load
   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = neighbor_byte;
      end else if (ctrl.load) begin
         data_in = load_byte;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Cells past the pattern length always agree
   assign eq   = !active || (data_ff == pattern_byte);
   assign data = data_ff;

endmodule

FILE: src/ssr_window.sv
module ssr_window
   import ssr_pkg::*;
(
   input  logic              clock,
   input  win_ctrl_type      ctrl,
   input  logic [BYTE_W-1:0] load_byte,
   input  logic [CSR_W-1:0]  pattern_bytes,
   input  logic [FILL_W-1:0] pattern_len,
   output logic [BYTE_W-1:0] head_byte,
   output logic              match
);

   logic [BYTE_W-1:0]      tap [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_eq;

   genvar k;
   generate
      for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
         cell_ctrl_type     cell_ctrl;
         logic [BYTE_W-1:0] neighbor;
         logic [BYTE_W-1:0] pat;

         assign cell_ctrl.shift = ctrl.shift;
         assign cell_ctrl.load  = ctrl.load[k];

         // Last cell pulls in zero on a shift
         if (k == PATTERN_MAX - 1) begin : g_end
            assign neighbor = '0;
         end else begin : g_mid
            assign neighbor = tap[k+1];
         end

         // Pattern bytes beyond the register are zero
         if (k < 8) begin : g_pat
            assign pat = pattern_bytes[8*k +: 8];
         end else begin : g_zero
            assign pat = '0;
         end

         ssr_cell u_cell (
            .clock         (clock),
            .ctrl          (cell_ctrl),
            .load_byte     (load_byte),
            .neighbor_byte (neighbor),
            .pattern_byte  (pat),
            .active        (FILL_W'(k) < pattern_len),
            .data          (tap[k]),
            .eq            (cell_eq[k])
         );
      end
   endgenerate

   assign head_byte = tap[0];
   assign match     = &cell_eq;

endmodule

FILE: src/stream_substring_replace.sv
// Streaming search and replace. Subject bytes enter on req_ (tlast marks the last byte of
// a string); every non-overlapping occurrence of the pattern is replaced by the replacement
// string, scanning left to right, and bytes left at the end of a string are flushed as is.
// An empty pattern passes bytes straight through. Results leave on rsp_ one byte per item;
// rsp_tlast marks the last item of a string, and when a string produces no byte a single
// empty item (tuser[0] low) carries it. Bytes beyond the output capacity are dropped and
// tuser[1] is raised on the last item. A byte that does not fill the window is stored;
// one that fills it is compared, then the oldest byte or, on a match, the replacement is
// sent; pass-through sends the byte as is; the end of a string flushes the window or sends
// the empty item. A new byte is taken only while the sequencer is idle. The single output
// register sends at most one byte per cycle, which bounds the rate, and a stalled consumer
// holds it. Configuration must be written only while the block is idle; the block does not
// enforce this. Writing pattern_length empties the window.
module stream_substring_replace
   import ssr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // Request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BYTE_W-1:0]    req_tdata,   // [7:0] subject_byte
   input  logic                 req_tlast,   // end_of_text
   // Result channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_W-1:0]    rsp_tdata,   // [7:0] text_byte
   output logic [1:0]           rsp_tuser,   // [0] byte_present, [1] truncated
   output logic                 rsp_tlast,   // final_item
   // Configuration port
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // Configuration registers
   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [RLEN_W-1:0] rlen_ff, rlen_in;
   logic [CSR_W-1:0]  pat_ff, pat_in;
   logic [CSR_W-1:0]  rlow_ff, rlow_in;
   logic [CSR_W-1:0]  rhigh_ff, rhigh_in;

   // Sequencer state
   state_type         state_ff, state_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              over_ff, over_in;
   logic              eot_ff, eot_in;
   logic              sent_ff, sent_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_present_ff, rsp_present_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_trunc_ff, rsp_trunc_in;

   // Window row
   win_ctrl_type      win_ctrl;
   logic [BYTE_W-1:0] win_head;
   logic              win_match;

   // Effective lengths
   logic [FILL_W-1:0] p_eff;
   logic [RLEN_W-1:0] r_eff;
   logic [FILL_W-1:0] ins_pos;
   logic [2*CSR_W-1:0] repl_all;
   logic [BYTE_W-1:0] repl_byte;

   // Per-cycle generation
   logic              out_free;
   logic              gen_valid;
   logic [BYTE_W-1:0] gen_byte;
   logic              gen_last;
   logic              emitted;
   logic              step_done;
   logic              done_sent;
   logic              fin;

   // Clamp the configured lengths
   always_comb begin
      if (32'(plen_ff) > 32'(PATTERN_MAX)) begin
         p_eff = FILL_W'(PATTERN_MAX);
      end else begin
         p_eff = FILL_W'(plen_ff);
      end
      if (32'(rlen_ff) > 32'(REPL_EFF_MAX)) begin
         r_eff = RLEN_W'(REPL_EFF_MAX);
      end else begin
         r_eff = rlen_ff;
      end
   end

   assign ins_pos   = (fill_ff >= p_eff) ? '0 : fill_ff;
   assign repl_all  = {rhigh_ff, rlow_ff};
   assign repl_byte = repl_all[{idx_ff, 3'b000} +: BYTE_W];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   ssr_window u_window (
      .clock         (clock),
      .ctrl          (win_ctrl),
      .load_byte     (req_tdata),
      .pattern_bytes (pat_ff),
      .pattern_len   (p_eff),
      .head_byte     (win_head),
      .match         (win_match)
   );

   // Next state and outputs
   always_comb begin
      plen_in        = plen_ff;
      rlen_in        = rlen_ff;
      pat_in         = pat_ff;
      rlow_in        = rlow_ff;
      rhigh_in       = rhigh_ff;
      state_in       = state_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      over_in        = over_ff;
      eot_in         = eot_ff;
      sent_in        = sent_ff;
      byte_in        = byte_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_byte_in    = rsp_byte_ff;
      rsp_present_in = rsp_present_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_trunc_in   = rsp_trunc_ff;
      win_ctrl       = '0;
      gen_valid      = 1'b0;
      gen_byte       = '0;
      gen_last       = 1'b0;
      emitted        = 1'b0;
      step_done      = 1'b0;
      fin            = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // Accept a request and drop it into the window
            if (req_tvalid) begin
               eot_in  = req_tlast;
               byte_in = req_tdata;
               sent_in = 1'b0;
               if (p_eff == '0) begin
                  state_in = ST_PASS;
               end else begin
                  for (int k = 0; k < PATTERN_MAX; k++) begin
                     win_ctrl.load[k] = (ins_pos == FILL_W'(k));
                  end
                  fill_in = ins_pos + FILL_W'(1);
                  if (ins_pos + FILL_W'(1) == p_eff) begin
                     state_in = ST_CHECK;
                  end else if (req_tlast) begin
                     state_in = ST_FLUSH;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_CHECK: begin
            // Compare the full window with the pattern
            if (win_match) begin
               fill_in = '0;
               if (r_eff != '0) begin
                  idx_in   = '0;
                  state_in = ST_REPL;
               end else begin
                  step_done = 1'b1;
               end
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_PASS: begin
            gen_valid = 1'b1;
            gen_byte  = byte_ff;
            gen_last  = 1'b1;
         end
         ST_REPL: begin
            // Send the replacement one byte per cycle while the output register is free
            gen_valid = 1'b1;
            gen_byte  = repl_byte;
            gen_last  = (RLEN_W'(idx_ff) + RLEN_W'(1)) == r_eff;
            if (out_free) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SHIFT: begin
            // Send the oldest byte and retry one byte later
            gen_valid = 1'b1;
            gen_byte  = win_head;
            gen_last  = !(eot_ff && (p_eff > FILL_W'(1)));
            if (out_free) begin
               win_ctrl.shift = 1'b1;
               fill_in        = p_eff - FILL_W'(1);
               if (!gen_last) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            // Drain the window at the end of a string
            gen_valid = 1'b1;
            gen_byte  = win_head;
            gen_last  = (fill_ff == FILL_W'(1));
            if (out_free) begin
               win_ctrl.shift = 1'b1;
               fill_in        = fill_ff - FILL_W'(1);
            end
         end
         ST_MARK: begin
            // Close an empty string with a marker item
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_byte_in    = '0;
               rsp_present_in = 1'b0;
               rsp_last_in    = 1'b1;
               rsp_trunc_in   = over_ff;
               count_in       = '0;
               over_in        = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Send a generated byte, or drop it at capacity
      if (gen_valid && out_free) begin
         if (count_ff < CNT_W'(OUTPUT_CAPACITY)) begin
            fin            = eot_ff &&
                             (gen_last || (count_ff == CNT_W'(OUTPUT_CAPACITY - 1)));
            rsp_valid_in   = 1'b1;
            rsp_byte_in    = gen_byte;
            rsp_present_in = 1'b1;
            rsp_last_in    = fin;
            rsp_trunc_in   = fin && (over_ff || !gen_last);
            count_in       = count_ff + CNT_W'(1);
            emitted        = 1'b1;
         end else begin
            over_in = 1'b1;
         end
         if (gen_last) begin
            step_done = 1'b1;
         end
      end

      // Close the step
      done_sent = sent_ff || emitted;
      sent_in   = (state_ff == ST_IDLE) ? sent_in : done_sent;
      if (step_done) begin
         if (eot_ff && done_sent) begin
            count_in = '0;
            over_in  = 1'b0;
            state_in = ST_IDLE;
         end else if (eot_ff) begin
            state_in = ST_MARK;
         end else begin
            state_in = ST_IDLE;
         end
      end

      // Configuration writes
      if (csr_we) begin
         case (csr_index)
            CSR_PATTERN_LENGTH: begin
               plen_in = csr_wdata[PLEN_W-1:0];
               fill_in = '0;
            end
            CSR_REPLACEMENT_LENGTH: rlen_in  = csr_wdata[RLEN_W-1:0];
            CSR_PATTERN_BYTES:      pat_in   = csr_wdata;
            CSR_REPLACEMENT_LOW:    rlow_in  = csr_wdata;
            CSR_REPLACEMENT_HIGH:   rhigh_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         rlen_ff      <= '0;
         pat_ff       <= '0;
         rlow_ff      <= '0;
         rhigh_ff     <= '0;
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         over_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         rlen_ff      <= rlen_in;
         pat_ff       <= pat_in;
         rlow_ff      <= rlow_in;
         rhigh_ff     <= rhigh_in;
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         over_ff      <= over_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      eot_ff         <= eot_in;
      sent_ff        <= sent_in;
      byte_ff        <= byte_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_present_ff <= rsp_present_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_trunc_ff   <= rsp_trunc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_trunc_ff, rsp_present_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
